[design/gsut_pkg.sv]
// Shared types and constants of the gas sensor serial transaction block.
// No dependencies; every other design file imports this package.
`default_nettype none

package gsut_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);
   localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_BYTES - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // frame marks
   localparam logic [7:0] START_MARK    = 8'hFF;
   localparam logic [7:0] RESERVED_MARK = 8'h01;
   localparam logic [7:0] CALIB_ON_MARK = 8'hA0;
   localparam logic [7:0] CALIB_ACK     = 8'h01;

   // frame byte positions
   localparam logic [FRAME_IDX_W-1:0] POS_START    = FRAME_IDX_W'(0);
   localparam logic [FRAME_IDX_W-1:0] POS_RESERVED = FRAME_IDX_W'(1);
   localparam logic [FRAME_IDX_W-1:0] POS_COMMAND  = FRAME_IDX_W'(2);
   localparam logic [FRAME_IDX_W-1:0] POS_HIGH     = FRAME_IDX_W'(3);
   localparam logic [FRAME_IDX_W-1:0] POS_LOW      = FRAME_IDX_W'(4);

   // input opcodes
   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_CALIB = 1'b1;

   localparam logic OUT_TX     = 1'b0;
   localparam logic OUT_STATUS = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_WARMING     = 3'd1;
   localparam logic [2:0] ST_BAD_START   = 3'd2;
   localparam logic [2:0] ST_BAD_SUM     = 3'd3;
   localparam logic [2:0] ST_WRONG_CMD   = 3'd4;
   localparam logic [2:0] ST_BAD_PAYLOAD = 3'd5;
   localparam logic [2:0] ST_TIMEOUT     = 3'd6;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_CMD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_CMD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP    = 2'd3;

   localparam logic [7:0]  RST_READ_CMD  = 8'd134;
   localparam logic [7:0]  RST_CALIB_CMD = 8'd121;
   localparam logic [9:0]  RST_TIMEOUT   = 10'd50;
   localparam logic [15:0] RST_WARMUP    = 16'd15000;

   typedef struct packed {
      logic [1:0] opcode;
      logic       request_kind;
      logic       calib_enable;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  status;
      logic [15:0] co2_ppm;
   } rsp_type;

   // work handed from the front to the back: a command frame or a status word
   typedef struct packed {
      logic        is_frame;
      logic [7:0]  command;
      logic [7:0]  data0;
      logic [2:0]  status;
      logic [15:0] co2_ppm;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

endpackage

`default_nettype wire

[design/gas_sensor_uart_transaction_top.sv]
// An accepted input word's job passes through the job queue and then the
// output register before its first response word shows on rsp_data.
// Input words are taken one per cycle while the four-entry job queue has
// room; a command frame holds the output for nine words, a status job for
// one. Reset is synchronous: it empties the queue, ends any transaction,
// restarts warm-up and loads register defaults.
`default_nettype none

module gas_sensor_uart_transaction_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire gsut_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output gsut_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [gsut_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gsut_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gsut_pkg::*;

   push_type q_push;
   logic     q_full;
   logic     q_valid;
   job_type  q_head;
   logic     q_pop;

   gsut_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   gsut_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   gsut_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[design/gsut_front.sv]
// Front: takes input words, tracks the transaction and warm-up state and the
// registers, and queues frame or status jobs. Depends on gsut_pkg.
`default_nettype none

module gsut_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire gsut_pkg::req_type                   req_data,
   input  wire logic                                csr_we,
   input  wire logic [gsut_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gsut_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                q_full,
   output gsut_pkg::push_type                       q_push
);
   import gsut_pkg::*;

   logic [7:0]             read_cmd_ff, read_cmd_in;
   logic [7:0]             calib_cmd_ff, calib_cmd_in;
   logic [9:0]             timeout_ff, timeout_in;
   logic [15:0]            warmup_ms_ff, warmup_ms_in;

   logic                   busy_ff, busy_in;
   logic                   pend_kind_ff, pend_kind_in;
   logic [FRAME_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [7:0]             sum_ff, sum_in;
   logic [7:0]             reply_cmd_ff, reply_cmd_in;
   logic [7:0]             reply_high_ff, reply_high_in;
   logic [7:0]             reply_low_ff, reply_low_in;
   logic                   tail_nz_ff, tail_nz_in;
   logic [9:0]             wait_ff, wait_in;
   logic [15:0]            warm_ff, warm_in;

   logic                   accept;
   logic                   push;
   job_type                job;
   logic                   warming;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign warming   = warm_ff < warmup_ms_ff;
   assign q_push    = '{push: push, job: job};

   always_comb begin
      read_cmd_in   = read_cmd_ff;
      calib_cmd_in  = calib_cmd_ff;
      timeout_in    = timeout_ff;
      warmup_ms_in  = warmup_ms_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_READ_CMD:  read_cmd_in  = csr_wdata[7:0];
            CSR_CALIB_CMD: calib_cmd_in = csr_wdata[7:0];
            CSR_TIMEOUT:   timeout_in   = csr_wdata[9:0];
            CSR_WARMUP:    warmup_ms_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      pend_kind_in  = pend_kind_ff;
      byte_idx_in   = byte_idx_ff;
      sum_in        = sum_ff;
      reply_cmd_in  = reply_cmd_ff;
      reply_high_in = reply_high_ff;
      reply_low_in  = reply_low_ff;
      tail_nz_in    = tail_nz_ff;
      wait_in       = wait_ff;
      warm_in       = warm_ff;
      push          = 1'b0;
      job           = '0;
      if (accept) begin
         unique case (req_data.opcode)
            OP_REQUEST: begin
               if (!busy_ff) begin
                  push = 1'b1;
                  if (warming) begin
                     job.status = ST_WARMING;
                  end else begin
                     job.is_frame  = 1'b1;
                     job.command   = (req_data.request_kind == KIND_CALIB) ?
                                     calib_cmd_ff : read_cmd_ff;
                     job.data0     = (req_data.request_kind == KIND_CALIB &&
                                      req_data.calib_enable) ? CALIB_ON_MARK : 8'd0;
                     busy_in       = 1'b1;
                     pend_kind_in  = req_data.request_kind;
                     byte_idx_in   = '0;
                     sum_in        = '0;
                     reply_cmd_in  = '0;
                     reply_high_in = '0;
                     reply_low_in  = '0;
                     tail_nz_in    = 1'b0;
                     wait_in       = '0;
                  end
               end
            end
            OP_RX_BYTE: begin
               if (busy_ff) begin
                  wait_in = '0;
                  if (byte_idx_ff == POS_START) begin
                     if (req_data.rx_byte != START_MARK) begin
                        push       = 1'b1;
                        job.status = ST_BAD_START;
                        busy_in    = 1'b0;
                     end else begin
                        byte_idx_in = POS_RESERVED;
                     end
                  end else if (byte_idx_ff != LAST_IDX) begin
                     sum_in      = sum_ff + req_data.rx_byte;
                     byte_idx_in = byte_idx_ff + FRAME_IDX_W'(1);
                     if (byte_idx_ff == POS_RESERVED)
                        reply_cmd_in = req_data.rx_byte;
                     else if (byte_idx_ff == POS_COMMAND)
                        reply_high_in = req_data.rx_byte;
                     else if (byte_idx_ff == POS_HIGH)
                        reply_low_in = req_data.rx_byte;
                     else if (req_data.rx_byte != 8'd0)
                        tail_nz_in = 1'b1;
                  end else begin
                     // checksum byte closes the reply
                     push    = 1'b1;
                     busy_in = 1'b0;
                     if (req_data.rx_byte != 8'(8'd0 - sum_ff))
                        job.status = ST_BAD_SUM;
                     else if (pend_kind_ff == KIND_READ) begin
                        if (reply_cmd_ff != read_cmd_ff)
                           job.status = ST_WRONG_CMD;
                        else
                           job.co2_ppm = {reply_high_ff, reply_low_ff};
                     end else if (reply_cmd_ff != calib_cmd_ff)
                        job.status = ST_WRONG_CMD;
                     else if (reply_high_ff != CALIB_ACK || reply_low_ff != 8'd0 ||
                              tail_nz_ff)
                        job.status = ST_BAD_PAYLOAD;
                  end
               end
            end
            OP_TICK: begin
               if (warming)
                  warm_in = warm_ff + 16'd1;
               if (busy_ff) begin
                  if (wait_ff >= timeout_ff) begin
                     push       = 1'b1;
                     job.status = ST_TIMEOUT;
                     busy_in    = 1'b0;
                  end else begin
                     wait_in = wait_ff + 10'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_cmd_ff   <= RST_READ_CMD;
         calib_cmd_ff  <= RST_CALIB_CMD;
         timeout_ff    <= RST_TIMEOUT;
         warmup_ms_ff  <= RST_WARMUP;
         busy_ff       <= 1'b0;
         pend_kind_ff  <= 1'b0;
         byte_idx_ff   <= '0;
         sum_ff        <= '0;
         reply_cmd_ff  <= '0;
         reply_high_ff <= '0;
         reply_low_ff  <= '0;
         tail_nz_ff    <= 1'b0;
         wait_ff       <= '0;
         warm_ff       <= '0;
      end else begin
         read_cmd_ff   <= read_cmd_in;
         calib_cmd_ff  <= calib_cmd_in;
         timeout_ff    <= timeout_in;
         warmup_ms_ff  <= warmup_ms_in;
         busy_ff       <= busy_in;
         pend_kind_ff  <= pend_kind_in;
         byte_idx_ff   <= byte_idx_in;
         sum_ff        <= sum_in;
         reply_cmd_ff  <= reply_cmd_in;
         reply_high_ff <= reply_high_in;
         reply_low_ff  <= reply_low_in;
         tail_nz_ff    <= tail_nz_in;
         wait_ff       <= wait_in;
         warm_ff       <= warm_in;
      end
   end

   // a transaction only ends together with its status job
   a_busy_end_pushes: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !busy_in |-> push && !job.is_frame)
      else $error("transaction ended without status");

   // a request during a transaction queues nothing
   a_busy_request_dropped: assert property (@(posedge clock) disable iff (reset)
      busy_ff && accept && req_data.opcode == OP_REQUEST |-> !push)
      else $error("request queued while busy");

endmodule

`default_nettype wire

[design/gsut_queue.sv]
// Short job queue between the front and the back.
// Depends on gsut_pkg.
`default_nettype none

module gsut_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gsut_pkg::push_type    q_push,
   output logic                       q_full,
   output logic                       q_valid,
   output gsut_pkg::job_type          q_head,
   input  wire logic                  q_pop
);
   import gsut_pkg::*;

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign q_full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_head  = mem[rd_ptr_ff];
   assign do_push = q_push.push && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem[wr_ptr_ff] <= q_push.job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // the front must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push.push)
      else $error("push into full queue");

endmodule

`default_nettype wire

[design/gsut_back.sv]
// Back: expands queued jobs into response words (nine frame bytes or one
// status word) behind an output register. Depends on gsut_pkg.
`default_nettype none

module gsut_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire gsut_pkg::job_type     q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output gsut_pkg::rsp_type          rsp_data
);
   import gsut_pkg::*;

   logic [FRAME_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   slot_free;
   logic                   emit;
   logic [7:0]             checksum;
   logic [7:0]             frame_byte;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = slot_free && q_valid;
   assign checksum  = 8'(8'd0 - RESERVED_MARK - q_head.command - q_head.data0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (idx_ff)
         POS_START:    frame_byte = START_MARK;
         POS_RESERVED: frame_byte = RESERVED_MARK;
         POS_COMMAND:  frame_byte = q_head.command;
         POS_HIGH:     frame_byte = q_head.data0;
         LAST_IDX:     frame_byte = checksum;
         default:      frame_byte = 8'd0;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (q_head.is_frame) begin
            rsp_data_in.out_kind = OUT_TX;
            rsp_data_in.tx_byte  = frame_byte;
            rsp_data_in.last     = idx_ff == LAST_IDX;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               q_pop  = 1'b1;
            end else begin
               idx_in = idx_ff + FRAME_IDX_W'(1);
            end
         end else begin
            rsp_data_in.out_kind = OUT_STATUS;
            rsp_data_in.status   = q_head.status;
            rsp_data_in.co2_ppm  = q_head.co2_ppm;
            q_pop                = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // mid-frame the head job must still be a frame
   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> q_valid && q_head.is_frame)
      else $error("frame job lost mid-frame");

endmodule

`default_nettype wire

[bench/tb_gas_sensor_uart_transaction_top.sv]
`timescale 1ns / 1ps
// Testbench for gas_sensor_uart_transaction_top: a directed table, then random sensor exchanges.
// Each response word is checked against its table entry or a cycle-free host-side model.
// Depends on gsut_pkg and the block's RTL only.

module tb_gas_sensor_uart_transaction_top;
   import gsut_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int HOLD_CYCLES         = 400;
   localparam int SETTLE_CYCLES       = 12;
   localparam int LIMIT_CYCLES        = 200000;
   localparam int SHOW_MAX            = 10;
   localparam int PLAN_SPLIT          = 5;

   typedef struct packed {
      req_type w;
      logic    typed;
      rsp_type r;
   } row_type;

   typedef struct packed {
      logic    typed;
      rsp_type r;
   } hint_type;

   localparam rsp_type NO_WORD        = '0;
   localparam rsp_type WARMING_WORD   = '{OUT_STATUS, 8'h00, 1'b0, ST_WARMING, 16'h0000};
   localparam rsp_type BAD_START_WORD = '{OUT_STATUS, 8'h00, 1'b0, ST_BAD_START, 16'h0000};
   localparam rsp_type TIMEOUT_WORD   = '{OUT_STATUS, 8'h00, 1'b0, ST_TIMEOUT, 16'h0000};
   localparam rsp_type CALIB_OK_WORD  = '{OUT_STATUS, 8'h00, 1'b0, ST_OK, 16'h0000};

   // rows before PLAN_SPLIT run on register defaults (warm-up still running);
   // the rest run with timeout 0 and warm-up lowered to the tick count so far
   localparam row_type PLAN [20] = '{
      '{'{OP_REQUEST, KIND_READ,  1'b0, 8'h00}, 1'b1, WARMING_WORD},
      '{'{OP_REQUEST, KIND_CALIB, 1'b1, 8'hFF}, 1'b1, WARMING_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b0, 8'hFF}, 1'b0, NO_WORD},
      '{'{OP_TICK,    KIND_CALIB, 1'b1, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_UNUSED,  KIND_CALIB, 1'b0, 8'hA5}, 1'b0, NO_WORD},
      '{'{OP_REQUEST, KIND_READ,  1'b1, 8'h5A}, 1'b0, NO_WORD},
      '{'{OP_REQUEST, KIND_CALIB, 1'b1, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_CALIB, 1'b1, 8'h00}, 1'b1, BAD_START_WORD},
      '{'{OP_REQUEST, KIND_CALIB, 1'b1, 8'hC3}, 1'b0, NO_WORD},
      '{'{OP_TICK,    KIND_READ,  1'b0, 8'hFF}, 1'b1, TIMEOUT_WORD},
      '{'{OP_REQUEST, KIND_CALIB, 1'b0, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b0, 8'hFF}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b1, 8'h79}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_CALIB, 1'b0, 8'h01}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b0, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_CALIB, 1'b1, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b0, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b1, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_CALIB, 1'b0, 8'h00}, 1'b0, NO_WORD},
      '{'{OP_RX_BYTE, KIND_READ,  1'b0, 8'h86}, 1'b1, CALIB_OK_WORD}
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_READ_CMD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // host-side model: registers and transaction state
   logic [7:0]  cfg_read_cmd  = RST_READ_CMD;
   logic [7:0]  cfg_calib_cmd = RST_CALIB_CMD;
   logic [9:0]  cfg_timeout   = RST_TIMEOUT;
   logic [15:0] cfg_warmup    = RST_WARMUP;
   logic        sensor_busy   = 1'b0;
   logic        sensor_kind   = KIND_READ;
   logic [3:0]  sensor_idx    = '0;
   logic [7:0]  sensor_sum    = '0;
   logic [7:0]  sensor_cmd    = '0;
   logic [7:0]  sensor_high   = '0;
   logic [7:0]  sensor_low    = '0;
   logic        sensor_tail   = 1'b0;
   logic [9:0]  sensor_wait   = '0;
   logic [15:0] sensor_warm   = '0;

   rsp_type  fresh_words[$];
   rsp_type  pending_words[$];
   hint_type typed_q[$];
   int       errors       = 0;
   int       shown        = 0;
   int       burst_left   = 0;
   int       cycles       = 0;
   logic     hold_pending = 1'b0;

   gas_sensor_uart_transaction_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void post_status(input logic [2:0] st, input logic [15:0] ppm);
      rsp_type r;
      r = '0;
      r.out_kind = OUT_STATUS;
      r.status = st;
      r.co2_ppm = ppm;
      sensor_busy = 1'b0;
      fresh_words.push_back(r);
   endfunction

   // one input word through the model; response words land in fresh_words
   function automatic void advance_sensor(input req_type w);
      logic [7:0] fb [FRAME_BYTES];
      logic [7:0] acc;
      rsp_type    r;
      fresh_words.delete();
      case (w.opcode)
         OP_REQUEST: begin
            if (sensor_busy) return;
            if (sensor_warm < cfg_warmup) begin
               post_status(ST_WARMING, 16'h0000);
               return;
            end
            fb[0] = START_MARK;
            fb[1] = RESERVED_MARK;
            fb[2] = (w.request_kind == KIND_CALIB) ? cfg_calib_cmd : cfg_read_cmd;
            fb[3] = (w.request_kind == KIND_CALIB && w.calib_enable) ? CALIB_ON_MARK : 8'h00;
            acc = fb[1] + fb[2] + fb[3];
            for (int i = 4; i < FRAME_BYTES - 1; i++) fb[i] = 8'h00;
            fb[FRAME_BYTES-1] = 8'h00 - acc;
            for (int i = 0; i < FRAME_BYTES; i++) begin
               r = '0;
               r.out_kind = OUT_TX;
               r.tx_byte = fb[i];
               r.last = (i == FRAME_BYTES - 1);
               fresh_words.push_back(r);
            end
            sensor_busy = 1'b1;
            sensor_kind = w.request_kind;
            sensor_idx = '0;
            sensor_sum = '0;
            sensor_cmd = '0;
            sensor_high = '0;
            sensor_low = '0;
            sensor_tail = 1'b0;
            sensor_wait = '0;
         end
         OP_RX_BYTE: begin
            if (!sensor_busy) return;
            sensor_wait = '0;
            if (sensor_idx == 4'd0) begin
               if (w.rx_byte != START_MARK) post_status(ST_BAD_START, 16'h0000);
               else sensor_idx = 4'd1;
            end else if (sensor_idx < 4'(FRAME_BYTES - 1)) begin
               sensor_sum = sensor_sum + w.rx_byte;
               // reply layout: echoed command, ppm high, ppm low, then four tail bytes
               case (sensor_idx)
                  4'd1: sensor_cmd = w.rx_byte;
                  4'd2: sensor_high = w.rx_byte;
                  4'd3: sensor_low = w.rx_byte;
                  default: if (w.rx_byte != 8'h00) sensor_tail = 1'b1;
               endcase
               sensor_idx = sensor_idx + 4'd1;
            end else if (w.rx_byte != 8'h00 - sensor_sum) begin
               post_status(ST_BAD_SUM, 16'h0000);
            end else if (sensor_kind == KIND_READ) begin
               if (sensor_cmd != cfg_read_cmd) post_status(ST_WRONG_CMD, 16'h0000);
               else post_status(ST_OK, {sensor_high, sensor_low});
            end else if (sensor_cmd != cfg_calib_cmd) begin
               post_status(ST_WRONG_CMD, 16'h0000);
            end else if (sensor_high != CALIB_ACK || sensor_low != 8'h00 || sensor_tail) begin
               post_status(ST_BAD_PAYLOAD, 16'h0000);
            end else begin
               post_status(ST_OK, 16'h0000);
            end
         end
         OP_TICK: begin
            if (sensor_warm < cfg_warmup) sensor_warm = sensor_warm + 16'd1;
            if (!sensor_busy) return;
            if (sensor_wait >= cfg_timeout) post_status(ST_TIMEOUT, 16'h0000);
            else sensor_wait = sensor_wait + 10'd1;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      hint_type h;
      rsp_type  want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            h = typed_q.pop_front();
            advance_sensor(req_data);
            if (h.typed) pending_words.push_back(h.r);
            else foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               errors++;
               if (shown < SHOW_MAX) begin
                  shown++;
                  $display("%0t: unexpected word kind=%0d tx=%h last=%0d st=%0d ppm=%0d",
                           $realtime, rsp_data.out_kind, rsp_data.tx_byte, rsp_data.last,
                           rsp_data.status, rsp_data.co2_ppm);
               end
            end else begin
               want = pending_words.pop_front();
               if (rsp_data.out_kind !== want.out_kind || rsp_data.tx_byte !== want.tx_byte ||
                   rsp_data.last !== want.last || rsp_data.status !== want.status ||
                   rsp_data.co2_ppm !== want.co2_ppm) begin
                  errors++;
                  if (shown < SHOW_MAX) begin
                     shown++;
                     $display("%0t: word mismatch exp kind=%0d tx=%h last=%0d st=%0d ppm=%0d",
                              $realtime, want.out_kind, want.tx_byte, want.last, want.status,
                              want.co2_ppm);
                     $display("          got kind=%0d tx=%h last=%0d st=%0d ppm=%0d",
                              rsp_data.out_kind, rsp_data.tx_byte, rsp_data.last,
                              rsp_data.status, rsp_data.co2_ppm);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("[gas_sensor_uart_transaction_top] ERROR");
         $finish;
      end
   end

   // receiver: stretches of steady, patchy or sparse ready, plus one long hold on request
   initial begin
      int mode;
      int stretch;
      forever begin
         mode = $urandom_range(0, 2);
         stretch = $urandom_range(8, 60);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_pending) begin
               hold_pending = 1'b0;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_word(input req_type w, input logic typed, input rsp_type r);
      hint_type h;
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      h.typed = typed;
      h.r = r;
      typed_q.push_back(h);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   function automatic req_type word_of(input logic [1:0] op, input logic k, input logic e,
                                       input logic [7:0] b);
      req_type w;
      w.opcode = op;
      w.request_kind = k;
      w.calib_enable = e;
      w.rx_byte = b;
      return w;
   endfunction

   // wait until the block has nothing left in flight
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_READ_CMD:  cfg_read_cmd = v[7:0];
         CSR_CALIB_CMD: cfg_calib_cmd = v[7:0];
         CSR_TIMEOUT:   cfg_timeout = v[9:0];
         CSR_WARMUP:    cfg_warmup = v[15:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] rd, input logic [CSR_DATA_W-1:0] cal,
                           input logic [CSR_DATA_W-1:0] tmo, input logic [CSR_DATA_W-1:0] wu);
      csr_write(CSR_READ_CMD, rd);
      csr_write(CSR_CALIB_CMD, cal);
      csr_write(CSR_TIMEOUT, tmo);
      csr_write(CSR_WARMUP, wu);
      csr_we <= 1'b0;
   endtask

   // one request and its reply, mostly well formed, sometimes broken on purpose
   task automatic run_exchange();
      logic [7:0] b [FRAME_BYTES];
      logic [7:0] acc;
      logic       k;
      int         variant;
      int         cut;
      int         spot;
      int         tick_max;
      k = 1'($urandom);
      variant = $urandom_range(0, 9);
      // a cut reply under a long timeout would need too many ticks
      if (variant == 1 && cfg_timeout > 10'd8) variant = 5;
      tick_max = (cfg_timeout > 10'd3) ? 3 : int'(cfg_timeout);
      send_word(word_of(OP_REQUEST, k, 1'($urandom), 8'($urandom)), 1'b0, NO_WORD);
      if ($urandom_range(0, 7) == 0)
         send_word(word_of(OP_REQUEST, ~k, 1'($urandom), 8'($urandom)), 1'b0, NO_WORD);
      b[0] = START_MARK;
      b[1] = (k == KIND_CALIB) ? cfg_calib_cmd : cfg_read_cmd;
      if (k == KIND_CALIB) begin
         b[2] = CALIB_ACK;
         for (int i = 3; i < FRAME_BYTES - 1; i++) b[i] = 8'h00;
      end else begin
         b[2] = 8'($urandom);
         b[3] = 8'($urandom);
         for (int i = 4; i < FRAME_BYTES - 1; i++)
            b[i] = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
      end
      case (variant)
         0: b[0] = 8'($urandom_range(0, 254));
         3: b[1] = b[1] ^ 8'($urandom_range(1, 255));
         4: begin
            spot = $urandom_range(2, FRAME_BYTES - 2);
            b[spot] = b[spot] ^ 8'($urandom_range(1, 255));
         end
         default: ;
      endcase
      acc = '0;
      for (int i = 1; i < FRAME_BYTES - 1; i++) acc = acc + b[i];
      b[FRAME_BYTES-1] = 8'h00 - acc;
      if (variant == 2) b[FRAME_BYTES-1] = b[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
      cut = (variant == 1) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
      for (int i = 0; i < cut; i++) begin
         // ticks between reply bytes stay within the allowed wait
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(0, tick_max))
               send_word(word_of(OP_TICK, 1'($urandom), 1'($urandom), 8'($urandom)),
                         1'b0, NO_WORD);
         if ($urandom_range(0, 15) == 0)
            send_word(word_of(OP_UNUSED, 1'($urandom), 1'($urandom), 8'($urandom)),
                      1'b0, NO_WORD);
         send_word(word_of(OP_RX_BYTE, 1'($urandom), 1'($urandom), b[i]), 1'b0, NO_WORD);
      end
      if (variant == 1)
         repeat (int'(cfg_timeout) + 1)
            send_word(word_of(OP_TICK, 1'($urandom), 1'($urandom), 8'($urandom)),
                      1'b0, NO_WORD);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (i == PLAN_SPLIT) begin
            settle();
            set_regs(16'(RST_READ_CMD), 16'(RST_CALIB_CMD), 16'h0000, 16'h0001);
         end
         send_word(PLAN[i].w, PLAN[i].typed, PLAN[i].r);
      end

      settle();
      set_regs(16'h0000, 16'h00FF, 16'hFC00, 16'h0000);
      repeat (2) run_exchange();

      settle();
      set_regs(16'hFFFF, 16'hFF00, 16'h03FF, 16'h0002);
      repeat (1) run_exchange();

      settle();
      set_regs(16'($urandom), 16'($urandom), 16'h0002, 16'hFFFF);
      repeat (1) run_exchange();

      settle();
      set_regs(16'($urandom), 16'($urandom), {6'($urandom), 10'($urandom_range(0, 5))},
               16'h0003);
      hold_pending = 1'b1;
      repeat (3) run_exchange();

      settle();
      if (errors == 0 && pending_words.size() == 0)
         $display("[gas_sensor_uart_transaction_top] OK");
      else
         $display("[gas_sensor_uart_transaction_top] ERROR");
      $finish;
   end

endmodule
